// File: rtl/core/rtml_pkg.sv
// Shared types and codes for the route table metric lookup block.
// Used by rtml_cell and route_table_metric_lookup_top; no dependencies.
package rtml_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned CostW   = 16;
  localparam int unsigned IfaceW  = 2;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOROUTE = 2'd2;
  localparam logic [1:0] ST_BOUND   = 2'd3;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // lookup token moving down the cell chain
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  dest;
    logic              found;
    logic [CostW-1:0]  cost;
    logic [IfaceW-1:0] iface;
  } token_t;

  // route write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  net;
    logic [AddrW-1:0]  mask;
    logic [CostW-1:0]  cost;
    logic [IfaceW-1:0] iface;
  } route_wr_t;

endpackage

// File: rtl/core/rtml_cell.sv
// One route slot of the lookup chain: holds a route and updates the passing token.
// Depends on rtml_pkg.
module rtml_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                [CNT_W-1:0] count_i,
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rtml_pkg::route_wr_t             wr_i,
  input  rtml_pkg::token_t                tok_i,
  output rtml_pkg::token_t                tok_o
);

  logic [rtml_pkg::AddrW-1:0]  net_q;
  logic [rtml_pkg::AddrW-1:0]  mask_q;
  logic [rtml_pkg::CostW-1:0]  cost_q;
  logic [rtml_pkg::IfaceW-1:0] iface_q;
  logic                        in_use;
  logic                        hit;
  logic                        take;
  rtml_pkg::token_t            tok_d;
  rtml_pkg::token_t            tok_q;

  assign in_use = CNT_W'(IDX) < count_i;
  assign hit    = tok_i.valid && in_use && ((tok_i.dest & mask_q) == net_q);
  assign take   = hit && (!tok_i.found || (cost_q < tok_i.cost));

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.cost  = cost_q;
      tok_d.iface = iface_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (count_i == CNT_W'(IDX))) begin
      net_q   <= wr_i.net;
      mask_q  <= wr_i.mask;
      cost_q  <= wr_i.cost;
      iface_q <= wr_i.iface;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/route_table_metric_lookup_top.sv
// Top level of the route table metric lookup block.
// Depends on rtml_pkg and rtml_cell.
//
// An item is taken when start is high and busy is low. Add items and lookups
// with a bound source give their result in the cycle after the transfer. A
// lookup walks a chain of TABLE_DEPTH cells, one route per cell and one cell
// per cycle, so its result is registered after it leaves the last cell, and
// busy stays high until then. Each result is shown for one cycle on
// result_valid_o and cannot be held off. Config writes are always ready.
module route_table_metric_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned NUM_IFACES  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic [rtml_pkg::AddrW-1:0]         address_i,
  input  logic [rtml_pkg::AddrW-1:0]         net_mask_i,
  input  logic [rtml_pkg::CostW-1:0]         route_cost_i,
  input  logic [rtml_pkg::IfaceW-1:0]        out_iface_i,
  input  logic [rtml_pkg::AddrW-1:0]         source_addr_i,
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic [rtml_pkg::IfaceW-1:0]        chosen_iface_o,
  output logic [rtml_pkg::AddrW-1:0]         chosen_source_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rtml_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rtml_pkg::AddrW-1:0]         cfg_data_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [rtml_pkg::AddrW-1:0]  iface_addr_q [rtml_pkg::NumRegs];
  logic [CntW-1:0]             count_d, count_q;
  logic                        busy_d, busy_q;
  logic                        res_valid_d, res_valid_q;
  logic [1:0]                  status_d, status_q;
  logic [rtml_pkg::IfaceW-1:0] iface_d, iface_q;
  logic [rtml_pkg::AddrW-1:0]  src_d, src_q;
  logic                        accept;
  logic                        unbound;
  logic                        has_room;
  rtml_pkg::route_wr_t         wr;
  rtml_pkg::token_t            tok [TABLE_DEPTH+1];
  rtml_pkg::token_t            tail;

  assign accept   = start && !busy_q;
  assign unbound  = (source_addr_i == '0) || (source_addr_i == '1);
  assign has_room = count_q < CntW'(TABLE_DEPTH);
  assign busy     = busy_q;
  assign cfg_ready_o = 1'b1;

  assign wr.en    = accept && (kind_i == rtml_pkg::KIND_ADD) && has_room;
  assign wr.net   = address_i;
  assign wr.mask  = net_mask_i;
  assign wr.cost  = route_cost_i;
  assign wr.iface = out_iface_i;

  assign tok[0].valid = accept && (kind_i == rtml_pkg::KIND_LOOKUP) && unbound;
  assign tok[0].dest  = address_i;
  assign tok[0].found = 1'b0;
  assign tok[0].cost  = '0;
  assign tok[0].iface = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rtml_cell #(
      .IDX   (g),
      .CNT_W (CntW)
    ) u_cell (
      .count_i (count_q),
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  assign tail = tok[TABLE_DEPTH];

  always_comb begin
    res_valid_d = 1'b0;
    status_d    = rtml_pkg::ST_OK;
    iface_d     = '0;
    src_d       = '0;
    if (tail.valid) begin
      res_valid_d = 1'b1;
      if (tail.found) begin
        status_d = rtml_pkg::ST_OK;
        iface_d  = tail.iface;
        if ({1'b0, tail.iface} < 3'(NUM_IFACES)) begin
          src_d = iface_addr_q[tail.iface];
        end
      end else begin
        status_d = rtml_pkg::ST_NOROUTE;
      end
    end else if (accept) begin
      if (kind_i == rtml_pkg::KIND_ADD) begin
        res_valid_d = 1'b1;
        status_d    = has_room ? rtml_pkg::ST_OK : rtml_pkg::ST_FULL;
      end else if (!unbound) begin
        res_valid_d = 1'b1;
        status_d    = rtml_pkg::ST_BOUND;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (tail.valid) begin
      busy_d = 1'b0;
    end else if (tok[0].valid) begin
      busy_d = 1'b1;
    end
  end

  assign count_d = wr.en ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < rtml_pkg::NumRegs; i++) begin
        iface_addr_q[i] <= '0;
      end
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && (cfg_index_i < rtml_pkg::CfgIdxW'(rtml_pkg::NumRegs))) begin
        iface_addr_q[cfg_index_i[1:0]] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    iface_q  <= iface_d;
    src_q    <= src_d;
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = status_q;
  assign chosen_iface_o  = iface_q;
  assign chosen_source_o = src_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("route count above table depth");

  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("lookup token left chain while idle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == rtml_pkg::ST_FULL)) |-> (count_q == CntW'(TABLE_DEPTH)))
    else $error("table full reported below depth");

  a_lookup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !busy_d) |=> result_valid_o)
    else $error("lookup finished without a result");

endmodule
